### rtl/sed_pkg.sv
`default_nettype none

package sed_pkg;

  // Most bytes one input beat can produce: backslash, x, held digit, byte.
  localparam int unsigned MaxBytes = 4;

  typedef enum logic [1:0] {
    MODE_PLAIN = 2'd0,
    MODE_ESC   = 2'd1,
    MODE_HEX1  = 2'd2,
    MODE_HEX2  = 2'd3
  } mode_t;

  // One decoded burst: count bytes from data[0] upward, last flags the final one.
  typedef struct packed {
    logic                       last;
    logic [2:0]                 count;
    logic [MaxBytes-1:0][7:0]   data;
  } cmd_t;

  // Front to queue.
  typedef struct packed {
    logic push;
    cmd_t cmd;
  } push_t;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LF     = 8'h66;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;
  localparam logic [7:0] CTL_LF    = 8'h0A;
  localparam logic [7:0] CTL_CR    = 8'h0D;
  localparam logic [7:0] CTL_TAB   = 8'h09;
  localparam logic [7:0] CTL_NUL   = 8'h00;

endpackage

`default_nettype wire

### rtl/sed_front.sv
`default_nettype none

module sed_front
  import sed_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  input  wire logic       q_full,
  output logic            in_stall,
  output push_t           push
);

  mode_t       mode;
  mode_t       mode_next;
  logic [7:0]  held;
  logic        accept;
  logic        plain_emit;
  logic [4:0]  hex_in;
  logic [4:0]  hex_held;
  cmd_t        cmd;

  // {is_hex, value}
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [7:0] d;
    begin
      d = 8'd0;
      if (c >= CH_ZERO && c <= CH_NINE) begin
        d = c - CH_ZERO;
        hex_decode = {1'b1, d[3:0]};
      end else if (c >= CH_LA && c <= CH_LF) begin
        d = c - CH_LA + 8'd10;
        hex_decode = {1'b1, d[3:0]};
      end else if (c >= CH_UA && c <= CH_UF) begin
        d = c - CH_UA + 8'd10;
        hex_decode = {1'b1, d[3:0]};
      end else begin
        hex_decode = 5'd0;
      end
    end
  endfunction

  assign accept     = in_valid && !q_full;
  assign in_stall   = q_full;
  assign plain_emit = !(in_byte == CH_BSLASH && !in_last);
  assign hex_in     = hex_decode(in_byte);
  assign hex_held   = hex_decode(held);

  always_comb begin
    mode_next = mode;
    if (accept) begin
      unique case (mode)
        MODE_PLAIN: mode_next = plain_emit ? MODE_PLAIN : MODE_ESC;
        MODE_ESC:   mode_next = (in_byte == CH_X && !in_last) ? MODE_HEX1 : MODE_PLAIN;
        MODE_HEX1: begin
          if (!in_last && hex_in[4]) mode_next = MODE_HEX2;
          else                       mode_next = plain_emit ? MODE_PLAIN : MODE_ESC;
        end
        MODE_HEX2: begin
          if (hex_in[4]) mode_next = MODE_PLAIN;
          else           mode_next = plain_emit ? MODE_PLAIN : MODE_ESC;
        end
        default:    mode_next = MODE_PLAIN;
      endcase
    end
  end

  always_comb begin
    cmd      = '0;
    cmd.last = in_last;
    unique case (mode)
      MODE_PLAIN: begin
        if (plain_emit) begin
          cmd.data[0] = in_byte;
          cmd.count   = 3'd1;
        end
      end
      MODE_ESC: begin
        cmd.count = 3'd1;
        priority if (in_byte == CH_N)      cmd.data[0] = CTL_LF;
        else if (in_byte == CH_R)          cmd.data[0] = CTL_CR;
        else if (in_byte == CH_T)          cmd.data[0] = CTL_TAB;
        else if (in_byte == CH_BSLASH)     cmd.data[0] = CH_BSLASH;
        else if (in_byte == CH_DQUOTE)     cmd.data[0] = CH_DQUOTE;
        else if (in_byte == CH_ZERO)       cmd.data[0] = CTL_NUL;
        else if (in_byte == CH_X) begin
          // wait for digits unless the string ends here
          cmd.data[0] = CH_BSLASH;
          cmd.data[1] = CH_X;
          cmd.count   = in_last ? 3'd2 : 3'd0;
        end else begin
          cmd.data[0] = CH_BSLASH;
          cmd.data[1] = in_byte;
          cmd.count   = 3'd2;
        end
      end
      MODE_HEX1: begin
        cmd.data[0] = CH_BSLASH;
        cmd.data[1] = CH_X;
        cmd.data[2] = in_byte;
        if (!in_last && hex_in[4]) cmd.count = 3'd0;
        else                       cmd.count = plain_emit ? 3'd3 : 3'd2;
      end
      MODE_HEX2: begin
        if (hex_in[4]) begin
          cmd.data[0] = {hex_held[3:0], hex_in[3:0]};
          cmd.count   = 3'd1;
        end else begin
          cmd.data[0] = CH_BSLASH;
          cmd.data[1] = CH_X;
          cmd.data[2] = held;
          cmd.data[3] = in_byte;
          cmd.count   = plain_emit ? 3'd4 : 3'd3;
        end
      end
      default: cmd = '0;
    endcase
  end

  assign push.push = accept && (cmd.count != 3'd0);
  assign push.cmd  = cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_PLAIN;
      held <= 8'd0;
    end else begin
      mode <= mode_next;
      if (accept && mode == MODE_HEX1) begin
        held <= in_byte;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/sed_queue.sv
`default_nettype none

module sed_queue
  import sed_pkg::*;
#(
  parameter int unsigned Depth = 4
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire push_t push,
  input  wire logic  pop,
  output logic       full,
  output logic       empty,
  output cmd_t       head
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign full    = (count == CntW'(Depth));
  assign empty   = (count == '0);
  assign do_push = push.push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push.cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push.push |-> !full) else $error("burst pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty) else $error("pop from empty queue");

endmodule

`default_nettype wire

### rtl/sed_back.sv
`default_nettype none

module sed_back
  import sed_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  q_empty,
  input  wire cmd_t  q_head,
  output logic       pop,
  output logic       out_valid,
  input  wire logic  out_stall,
  output logic [7:0] out_byte,
  output logic       out_last
);

  cmd_t       cur;
  logic       cur_valid;
  logic [1:0] idx;
  logic       last_beat;
  logic       advance;
  logic       take;

  assign last_beat = (({1'b0, idx} + 3'd1) == cur.count);
  assign take      = cur_valid && !out_stall;
  assign advance   = !cur_valid || (take && last_beat);
  assign pop       = advance && !q_empty;

  assign out_valid = cur_valid;
  assign out_byte  = cur.data[idx];
  assign out_last  = cur.last && last_beat;

  always_ff @(posedge clk) begin
    if (advance) begin
      cur <= q_head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (advance) begin
      cur_valid <= !q_empty;
      idx       <= 2'd0;
    end else if (take) begin
      idx <= idx + 2'd1;
    end
  end

  a_count_legal: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> (cur.count != 3'd0 && cur.count <= 3'(MaxBytes)))
    else $error("held burst has an illegal byte count");

  a_mid_burst_holds: assert property (@(posedge clk) disable iff (rst)
    (take && !last_beat) |=> (cur_valid && idx == $past(idx) + 2'd1))
    else $error("burst dropped before its final byte");

endmodule

`default_nettype wire

### rtl/string_escape_decoder.sv
`default_nettype none
// Path: an input beat's decoded bytes are written into the burst queue and then loaded
//   into the output register, from which they are presented.
// Throughput: one input beat per cycle while the queue has room; the output side sends
//   one byte per cycle while not stalled; a k-byte beat holds the back end till all are sent.
// Input stall rises only when the burst queue (QueueDepth entries) is full.
// Reset (rst, synchronous, active high) returns the parser to plain text and empties
//   the queue and the output register.

module string_escape_decoder
  import sed_pkg::*;
#(
  parameter int unsigned QueueDepth = 4
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            out_last
);

  push_t push;
  cmd_t  q_head;
  logic  q_full;
  logic  q_empty;
  logic  pop;

  // Front end: run the escape parser on each accepted beat and turn it into
  // a burst of zero to four bytes; empty bursts are dropped here.
  sed_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .q_full   (q_full),
    .in_stall (in_stall),
    .push     (push)
  );

  // Burst queue: lets the parser keep taking beats while the back end drains
  // a long burst or waits on a stalled output.
  sed_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .pop   (pop),
    .full  (q_full),
    .empty (q_empty),
    .head  (q_head)
  );

  // Back end: hold one burst in the output register and send its bytes one
  // beat at a time; load the next burst on the final byte's handshake.
  sed_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

endmodule

`default_nettype wire
